// ===== design/chr_pkg.sv =====
// Package for the consistent hash ring: sizes, codes and shared types.
// Used by every module of the ring; depends on nothing.
`timescale 1ns / 1ps

package chr_pkg;

  localparam int RING_SIZE  = 256;
  localparam int HASH_W     = 34;
  localparam int OWNER_W    = 8;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int HELD_W     = 9;
  localparam int CNT_W      = $clog2(RING_SIZE + 1);
  localparam int GRP_SIZE   = 16;
  localparam int NUM_GRP    = (RING_SIZE + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_SIZE   = NUM_GRP * GRP_SIZE;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USED_W = STATUS_W + OWNER_W + HELD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ABSENT    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic               valid;
    logic [HASH_W-1:0]  hash;
    logic [OWNER_W-1:0] owner;
  } cell_data_t;

  typedef struct packed {
    logic               hit;
    logic               eq;
    logic [OWNER_W-1:0] owner;
  } grp_t;

endpackage

// ===== design/chr_cell.sv =====
// One ring cell: holds one point, compares it with the key and shifts
// toward its neighbors on insert or remove. Depends on chr_pkg.
`timescale 1ns / 1ps

module chr_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  chr_pkg::cell_ctrl_t         ctrl_i,
  input  logic [chr_pkg::HASH_W-1:0]  cmp_key_i,
  input  logic [chr_pkg::HASH_W-1:0]  ins_key_i,
  input  logic [chr_pkg::OWNER_W-1:0] ins_owner_i,
  input  chr_pkg::cell_data_t         left_i,
  input  logic                        left_g_i,
  input  chr_pkg::cell_data_t         right_i,
  output chr_pkg::cell_data_t         data_o,
  output logic                        g_o,
  output logic                        eq_o,
  output logic                        hit_o,
  output logic [chr_pkg::OWNER_W-1:0] hit_owner_o
);

  logic                        valid_q, valid_d;
  logic [chr_pkg::HASH_W-1:0]  hash_q, hash_d;
  logic [chr_pkg::OWNER_W-1:0] owner_q, owner_d;
  logic                        g_q, g_d;
  logic                        eq_q, eq_d;

  always_comb begin
    valid_d = valid_q;
    hash_d  = hash_q;
    owner_d = owner_q;
    g_d     = g_q;
    eq_d    = eq_q;
    if (ctrl_i.cmp_en) begin
      g_d  = !valid_q || (hash_q >= cmp_key_i);
      eq_d = valid_q && (hash_q == cmp_key_i);
    end
    if (ctrl_i.ins_en && g_q) begin
      if (!left_g_i) begin
        valid_d = 1'b1;
        hash_d  = ins_key_i;
        owner_d = ins_owner_i;
      end else begin
        valid_d = left_i.valid;
        hash_d  = left_i.hash;
        owner_d = left_i.owner;
      end
    end
    if (ctrl_i.rem_en && g_q) begin
      valid_d = right_i.valid;
      hash_d  = right_i.hash;
      owner_d = right_i.owner;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      g_q     <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      g_q     <= g_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q  <= hash_d;
    owner_q <= owner_d;
  end

  assign data_o      = '{valid: valid_q, hash: hash_q, owner: owner_q};
  assign g_o         = g_q;
  assign eq_o        = eq_q;
  assign hit_o       = valid_q && g_q && !left_g_i;
  assign hit_owner_o = hit_o ? owner_q : '0;

endmodule

// ===== design/chr_reduce.sv =====
// First level of the registered OR tree over the cell flags and owners.
// Depends on chr_pkg.
`timescale 1ns / 1ps

module chr_reduce (
  input  logic                        clk_i,
  input  logic [chr_pkg::RING_SIZE-1:0] hit_i,
  input  logic [chr_pkg::RING_SIZE-1:0] eq_i,
  input  logic [chr_pkg::OWNER_W-1:0] owner_i [chr_pkg::RING_SIZE],
  output chr_pkg::grp_t               grp_o [chr_pkg::NUM_GRP]
);

  logic [chr_pkg::PAD_SIZE-1:0] hit_pad;
  logic [chr_pkg::PAD_SIZE-1:0] eq_pad;
  logic [chr_pkg::OWNER_W-1:0]  owner_pad [chr_pkg::PAD_SIZE];
  chr_pkg::grp_t                grp_d [chr_pkg::NUM_GRP];
  chr_pkg::grp_t                grp_q [chr_pkg::NUM_GRP];

  for (genvar i = 0; i < chr_pkg::PAD_SIZE; i++) begin : g_pad
    if (i < chr_pkg::RING_SIZE) begin : g_real
      assign hit_pad[i]   = hit_i[i];
      assign eq_pad[i]    = eq_i[i];
      assign owner_pad[i] = owner_i[i];
    end else begin : g_zero
      assign hit_pad[i]   = 1'b0;
      assign eq_pad[i]    = 1'b0;
      assign owner_pad[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < chr_pkg::NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < chr_pkg::GRP_SIZE; j++) begin
        grp_d[g].hit   = grp_d[g].hit | hit_pad[g*chr_pkg::GRP_SIZE + j];
        grp_d[g].eq    = grp_d[g].eq | eq_pad[g*chr_pkg::GRP_SIZE + j];
        grp_d[g].owner = grp_d[g].owner | owner_pad[g*chr_pkg::GRP_SIZE + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

// ===== design/consistent_hash_ring.sv =====
// Consistent hash ring top level: a sorted chain of point cells, an OR tree and the control FSM.
// A new request is accepted only once the last one has left S_FINISH; the steps are compare in
// all cells, group OR, final select and shift, and S_FINISH stalls while the output register is full.
// The output register lets the next request be accepted while a result waits.
// Reset clears the point count and the cell valid bits at once; no clearing pass is needed.
// Depends on chr_pkg, chr_cell and chr_reduce.
`timescale 1ns / 1ps

module consistent_hash_ring (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0: key_hash[33:0], owner_node[41:34], zero fill.
  input  logic [chr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: command[1:0].
  input  logic [chr_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Fields from bit 0: status[2:0], served_node[10:3], points_held[19:11], zero fill.
  output logic [chr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  chr_pkg::state_e               state_q, state_d;
  chr_pkg::cmd_e                 cmd_q;
  logic [chr_pkg::HASH_W-1:0]    key_q;
  logic [chr_pkg::OWNER_W-1:0]   owner_q;
  logic [chr_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  logic [chr_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                          s_fire;
  logic                          finish;
  chr_pkg::cell_ctrl_t           ctrl;
  chr_pkg::status_e              status;
  logic [chr_pkg::OWNER_W-1:0]   served;
  logic                          do_ins, do_rem;

  chr_pkg::cell_data_t           cell_data [chr_pkg::RING_SIZE];
  logic [chr_pkg::RING_SIZE-1:0] cell_g;
  logic [chr_pkg::RING_SIZE-1:0] cell_eq;
  logic [chr_pkg::RING_SIZE-1:0] cell_hit;
  logic [chr_pkg::RING_SIZE-1:0] valid_vec;
  logic [chr_pkg::OWNER_W-1:0]   cell_hit_owner [chr_pkg::RING_SIZE];
  chr_pkg::grp_t                 grp [chr_pkg::NUM_GRP];

  logic                          any_hit, any_eq;
  logic [chr_pkg::OWNER_W-1:0]   or_owner;
  logic [chr_pkg::CNT_W+chr_pkg::HELD_W-1:0] held_ext;

  localparam chr_pkg::cell_data_t EDGE_DATA = '0;

  assign s_axis_tready_o = (state_q == chr_pkg::S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign finish          = (state_q == chr_pkg::S_FINISH) && (!out_valid_q || m_axis_tready_i);

  assign ctrl.cmp_en = s_fire;
  assign ctrl.ins_en = finish && do_ins;
  assign ctrl.rem_en = finish && do_rem;

  for (genvar i = 0; i < chr_pkg::RING_SIZE; i++) begin : g_cell
    chr_pkg::cell_data_t left_data, right_data;
    logic                left_g;
    if (i == 0) begin : g_first
      assign left_data = EDGE_DATA;
      assign left_g    = 1'b0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_g    = cell_g[i-1];
    end
    if (i == chr_pkg::RING_SIZE - 1) begin : g_last
      assign right_data = EDGE_DATA;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    chr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cmp_key_i   (s_axis_tdata_i[chr_pkg::HASH_W-1:0]),
      .ins_key_i   (key_q),
      .ins_owner_i (owner_q),
      .left_i      (left_data),
      .left_g_i    (left_g),
      .right_i     (right_data),
      .data_o      (cell_data[i]),
      .g_o         (cell_g[i]),
      .eq_o        (cell_eq[i]),
      .hit_o       (cell_hit[i]),
      .hit_owner_o (cell_hit_owner[i])
    );

    assign valid_vec[i] = cell_data[i].valid;
  end

  chr_reduce u_reduce (
    .clk_i   (clk_i),
    .hit_i   (cell_hit),
    .eq_i    (cell_eq),
    .owner_i (cell_hit_owner),
    .grp_o   (grp)
  );

  always_comb begin
    any_hit  = 1'b0;
    any_eq   = 1'b0;
    or_owner = '0;
    for (int g = 0; g < chr_pkg::NUM_GRP; g++) begin
      any_hit  = any_hit | grp[g].hit;
      any_eq   = any_eq | grp[g].eq;
      or_owner = or_owner | grp[g].owner;
    end
  end

  always_comb begin
    status = chr_pkg::ST_DONE;
    served = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    case (cmd_q)
      chr_pkg::CMD_INSERT: begin
        if (any_eq) begin
          status = chr_pkg::ST_DUPLICATE;
        end else if (count_q == chr_pkg::CNT_W'(chr_pkg::RING_SIZE)) begin
          status = chr_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      chr_pkg::CMD_REMOVE: begin
        if (any_eq) begin
          do_rem = 1'b1;
        end else begin
          status = chr_pkg::ST_ABSENT;
        end
      end
      chr_pkg::CMD_LOOKUP: begin
        if (count_q == '0) begin
          status = chr_pkg::ST_EMPTY;
        end else if (any_hit) begin
          served = or_owner;
        end else begin
          served = cell_data[0].owner;
        end
      end
      default: begin
        status = chr_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + chr_pkg::CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - chr_pkg::CNT_W'(1);
    end
  end

  assign held_ext = (chr_pkg::CNT_W + chr_pkg::HELD_W)'(count_d);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      chr_pkg::S_IDLE: begin
        if (s_fire) begin
          state_d = chr_pkg::S_REDUCE;
        end
      end
      chr_pkg::S_REDUCE: begin
        state_d = chr_pkg::S_FINISH;
      end
      chr_pkg::S_FINISH: begin
        if (finish) begin
          out_valid_d = 1'b1;
          out_data_d  = {(chr_pkg::OUT_DATA_W - chr_pkg::OUT_USED_W)'(0),
                         held_ext[chr_pkg::HELD_W-1:0], served, status};
          state_d     = chr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = chr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chr_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= finish ? count_d : count_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (s_fire) begin
      cmd_q   <= chr_pkg::cmd_e'(s_axis_tuser_i);
      key_q   <= s_axis_tdata_i[chr_pkg::HASH_W-1:0];
      owner_q <= s_axis_tdata_i[chr_pkg::HASH_W +: chr_pkg::OWNER_W];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= chr_pkg::CNT_W'(chr_pkg::RING_SIZE))
    else $error("point count exceeds ring size");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell valid bits disagree with point count");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && do_ins) |=> (count_q == $past(count_q) + chr_pkg::CNT_W'(1)))
    else $error("insert did not advance the point count");
`endif

endmodule

// ===== bench/tb_consistent_hash_ring.sv =====
// Testbench for consistent_hash_ring: directed table, then phased random traffic
// checked against a sorted-ring predictor. Depends on chr_pkg and the ring RTL only.
`timescale 1ns / 1ps

module tb_consistent_hash_ring;

  localparam logic [chr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AFTER = 60;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_MIX = 0;
  localparam int PHASE_FILL = 1;
  localparam int PHASE_FULL = 2;
  localparam int PHASE_DRAIN = 3;
  localparam int NUM_OPENING = 22;

  typedef struct packed {
    chr_pkg::status_e            status;
    logic [chr_pkg::OWNER_W-1:0] served;
    logic [chr_pkg::HELD_W-1:0]  held;
  } ring_result_t;

  typedef struct packed {
    logic [chr_pkg::CMD_W-1:0]   cmd;
    logic [chr_pkg::HASH_W-1:0]  hash;
    logic [chr_pkg::OWNER_W-1:0] owner;
    logic                        typed;
    chr_pkg::status_e            status;
    logic [chr_pkg::OWNER_W-1:0] served;
    logic [chr_pkg::HELD_W-1:0]  held;
  } opening_row_t;

  localparam opening_row_t OPENING_ROWS [NUM_OPENING] = '{
    '{chr_pkg::CMD_LOOKUP, 34'h0_0000_0000, 8'h00, 1'b1, chr_pkg::ST_EMPTY,     8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h3_FFFF_FFFF, 8'h00, 1'b1, chr_pkg::ST_ABSENT,    8'h00, 9'd0},
    '{CMD_UNUSED,          34'h3_FFFF_FFFF, 8'hFF, 1'b1, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_INSERT, 34'h0_0000_0000, 8'hFF, 1'b1, chr_pkg::ST_DONE,      8'h00, 9'd1},
    '{chr_pkg::CMD_INSERT, 34'h3_FFFF_FFFF, 8'h00, 1'b1, chr_pkg::ST_DONE,      8'h00, 9'd2},
    '{chr_pkg::CMD_INSERT, 34'h0_0000_0000, 8'h07, 1'b1, chr_pkg::ST_DUPLICATE, 8'h00, 9'd2},
    '{chr_pkg::CMD_LOOKUP, 34'h0_0000_0000, 8'h00, 1'b1, chr_pkg::ST_DONE,      8'hFF, 9'd2},
    '{chr_pkg::CMD_LOOKUP, 34'h0_0000_0001, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_LOOKUP, 34'h3_FFFF_FFFF, 8'hFF, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_INSERT, 34'h2_0000_0000, 8'hAA, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_INSERT, 34'h1_5555_5555, 8'h55, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_LOOKUP, 34'h1_FFFF_FFFF, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_LOOKUP, 34'h1_5555_5556, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h3_FFFF_FFFF, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_LOOKUP, 34'h2_0000_0001, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h0_0000_0005, 8'h00, 1'b1, chr_pkg::ST_ABSENT,    8'h00, 9'd3},
    '{CMD_UNUSED,          34'h0_0000_0000, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h0_0000_0000, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h0_0000_0000, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h2_0000_0000, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_REMOVE, 34'h1_5555_5555, 8'h00, 1'b0, chr_pkg::ST_DONE,      8'h00, 9'd0},
    '{chr_pkg::CMD_LOOKUP, 34'h3_FFFF_FFFF, 8'h00, 1'b1, chr_pkg::ST_EMPTY,     8'h00, 9'd0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [chr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [chr_pkg::CMD_W-1:0]      s_axis_tuser_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [chr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  logic [chr_pkg::HASH_W-1:0]  ring_hash [chr_pkg::RING_SIZE];
  logic [chr_pkg::OWNER_W-1:0] ring_owner [chr_pkg::RING_SIZE];
  int                          ring_count;
  ring_result_t                pending_results [$];
  int                          mismatch_count;
  int                          accepted_items;
  int                          burst_left;
  int                          cycle_count;
  bit                          long_hold_done;

  consistent_hash_ring DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic ring_result_t ring_apply(logic [chr_pkg::CMD_W-1:0] cmd,
                                              logic [chr_pkg::HASH_W-1:0] key,
                                              logic [chr_pkg::OWNER_W-1:0] owner);
    ring_result_t res;
    int pos;
    res = '{chr_pkg::ST_DONE, '0, '0};
    pos = 0;
    while (pos < ring_count && ring_hash[pos] < key) pos++;
    if (cmd == chr_pkg::CMD_INSERT) begin
      if (pos < ring_count && ring_hash[pos] == key) begin
        res.status = chr_pkg::ST_DUPLICATE;
      end else if (ring_count >= chr_pkg::RING_SIZE) begin
        res.status = chr_pkg::ST_FULL;
      end else begin
        for (int i = ring_count; i > pos; i--) begin
          ring_hash[i] = ring_hash[i-1];
          ring_owner[i] = ring_owner[i-1];
        end
        ring_hash[pos] = key;
        ring_owner[pos] = owner;
        ring_count++;
      end
    end else if (cmd == chr_pkg::CMD_REMOVE) begin
      if (pos < ring_count && ring_hash[pos] == key) begin
        for (int i = pos; i < ring_count - 1; i++) begin
          ring_hash[i] = ring_hash[i+1];
          ring_owner[i] = ring_owner[i+1];
        end
        ring_count--;
      end else begin
        res.status = chr_pkg::ST_ABSENT;
      end
    end else if (cmd == chr_pkg::CMD_LOOKUP) begin
      if (ring_count == 0) begin
        res.status = chr_pkg::ST_EMPTY;
      end else begin
        if (pos >= ring_count) pos = 0;
        res.served = ring_owner[pos];
      end
    end
    res.held = ring_count[chr_pkg::HELD_W-1:0];
    return res;
  endfunction

  function automatic logic [chr_pkg::HASH_W-1:0] random_hash();
    logic [chr_pkg::HASH_W-1:0] h;
    h = {2'($urandom_range(3, 0)), 32'($urandom)};
    return h;
  endfunction

  function automatic logic [chr_pkg::HASH_W-1:0] held_hash();
    if (ring_count == 0) return random_hash();
    return ring_hash[$urandom_range(ring_count - 1, 0)];
  endfunction

  function automatic logic [chr_pkg::HASH_W-1:0] probe_hash();
    int r;
    r = $urandom_range(3, 0);
    if (r == 0) return held_hash();
    if (r == 1) return held_hash() + 34'd1;
    if (r == 2) return held_hash() - 34'd1;
    return random_hash();
  endfunction

  task automatic pick_item(input int phase, output logic [chr_pkg::CMD_W-1:0] cmd,
                           output logic [chr_pkg::HASH_W-1:0] key,
                           output logic [chr_pkg::OWNER_W-1:0] owner);
    int r;
    r = $urandom_range(99, 0);
    owner = 8'($urandom_range(255, 0));
    cmd = chr_pkg::CMD_LOOKUP;
    key = probe_hash();
    case (phase)
      PHASE_MIX: begin
        if (r < 40) begin
          cmd = chr_pkg::CMD_INSERT;
          key = ($urandom_range(4, 0) == 0) ? held_hash() : random_hash();
        end else if (r < 65) begin
          cmd = chr_pkg::CMD_REMOVE;
          key = ($urandom_range(9, 0) < 7) ? held_hash() : random_hash();
        end else if (r >= 95) begin
          cmd = CMD_UNUSED;
          key = random_hash();
        end
      end
      PHASE_FILL: begin
        if (r < 85) begin
          cmd = chr_pkg::CMD_INSERT;
          key = ($urandom_range(9, 0) == 0) ? held_hash() : random_hash();
        end
      end
      PHASE_FULL: begin
        if (r < 40) begin
          cmd = chr_pkg::CMD_INSERT;
          key = random_hash();
        end else if (r < 60) begin
          cmd = chr_pkg::CMD_INSERT;
          key = held_hash();
        end else if (r >= 90) begin
          cmd = chr_pkg::CMD_REMOVE;
          key = held_hash();
        end
      end
      default: begin
        if (r < 75) begin
          cmd = chr_pkg::CMD_REMOVE;
          key = held_hash();
        end else if (r >= 95) begin
          cmd = chr_pkg::CMD_INSERT;
          key = random_hash();
        end
      end
    endcase
  endtask

  task automatic send_request(input logic [chr_pkg::CMD_W-1:0] cmd,
                              input logic [chr_pkg::HASH_W-1:0] key,
                              input logic [chr_pkg::OWNER_W-1:0] owner, input bit typed,
                              input ring_result_t typed_res);
    ring_result_t predicted;
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(chr_pkg::IN_DATA_W - chr_pkg::HASH_W - chr_pkg::OWNER_W){1'b0}},
                       owner, key};
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = ring_apply(cmd, key, owner);
    pending_results.push_back(typed ? typed_res : predicted);
    accepted_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? 80 : $urandom_range(16, 1);
      gap = $urandom_range(8, 0);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic run_phase(input int phase, input int max_items);
    logic [chr_pkg::CMD_W-1:0] cmd;
    logic [chr_pkg::HASH_W-1:0] key;
    logic [chr_pkg::OWNER_W-1:0] owner;
    for (int n = 0; n < max_items; n++) begin
      if (phase == PHASE_FILL && ring_count >= chr_pkg::RING_SIZE) break;
      if (phase == PHASE_DRAIN && ring_count == 0) break;
      pick_item(phase, cmd, key, owner);
      send_request(cmd, key, owner, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("consistent_hash_ring verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    ring_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[2:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tdata_o[2:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[10:3] !== want.served) begin
          $display("%0t: served_node expected %0d actual %0d", $time, want.served,
                   m_axis_tdata_o[10:3]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[19:11] !== want.held) begin
          $display("%0t: points_held expected %0d actual %0d", $time, want.held,
                   m_axis_tdata_o[19:11]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    int run;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && accepted_items >= HOLD_AFTER) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      m_axis_tready_i <= 1'b1;
      run = $urandom_range(24, 1) + (($urandom_range(7, 0) == 0) ? 60 : 0);
      repeat (run) @(posedge clk_i);
      stall = $urandom_range(6, 0);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    opening_row_t row;
    ring_count = 0;
    mismatch_count = 0;
    accepted_items = 0;
    cycle_count = 0;
    long_hold_done = 1'b0;
    burst_left = $urandom_range(16, 1);
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_OPENING; i++) begin
      row = OPENING_ROWS[i];
      send_request(row.cmd, row.hash, row.owner, row.typed, '{row.status, row.served, row.held});
    end

    run_phase(PHASE_MIX, 60);
    run_phase(PHASE_FILL, 600);
    run_phase(PHASE_FULL, 40);
    run_phase(PHASE_DRAIN, 60);
    run_phase(PHASE_MIX, 20);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("consistent_hash_ring verification clean");
    end else begin
      $display("consistent_hash_ring verification failed");
    end
    $finish;
  end

endmodule
